// ----- hdl/rfa_pkg.sv -----
// Shared types, address constants and ALU functions of the raster frame-buffer device.
`default_nettype none

package rfa_pkg;

  // Request kinds carried by in_req_type.
  localparam logic [1:0] REQ_READ   = 2'd0;
  localparam logic [1:0] REQ_WORD   = 2'd1;
  localparam logic [1:0] REQ_BYTE   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Bus address map (18-bit byte addresses).
  localparam logic [17:0] WIN_LO    = 18'o060000;
  localparam logic [17:0] WIN_HI    = 18'o160000;
  localparam logic [17:0] CSA_ADDR  = 18'o157776;
  localparam logic [17:0] CTRL_ADDR = 18'o764044;
  localparam logic [17:0] CTRL_SPARE_ADDR = 18'o764046;
  localparam logic [17:0] KSTAT_ADDR = 18'o764050;
  localparam logic [17:0] KADDR_ADDR = 18'o764052;
  localparam logic [17:0] VSW_ADDR  = 18'o764060;
  localparam logic [17:0] ASW_ADDR  = 18'o770670;

  // Word offset of the window base.
  localparam logic [16:0] WIN_WORD_BASE = 17'o030000;

  // Keyboard register field masks.
  localparam logic [15:0] KSTAT_MASK   = 16'o177740;
  localparam logic [15:0] KADDR_HI_MASK = 16'o177600;
  localparam logic [6:0]  KADDR_LO_MASK = 7'o174;

  // Register targets outside the frame-buffer window.
  typedef enum logic [2:0] {
    REG_NONE  = 3'd0,
    REG_CTRL  = 3'd1,
    REG_KSTAT = 3'd2,
    REG_KADDR = 3'd3,
    REG_DUMMY = 3'd4
  } reg_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic rd;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
  } sts_t;

  // Boolean ALU: a is the old value, b is the bus data.
  function automatic logic [15:0] alu_apply(input logic [7:0] op, input logic [15:0] a,
                                            input logic [15:0] b);
    logic [15:0] r;
    unique case (op)
      8'd0:    r = ~b;
      8'd1:    r = ~(a | b);
      8'd2:    r = a & ~b;
      8'd3:    r = 16'h0000;
      8'd4:    r = ~(a & b);
      8'd5:    r = ~a;
      8'd6:    r = a ^ b;
      8'd7:    r = ~a & b;
      8'd8:    r = a | ~b;
      8'd9:    r = ~(a ^ b);
      8'd10:   r = a;
      8'd11:   r = a & b;
      8'd12:   r = ~a | b;
      8'd13:   r = 16'hFFFF;
      8'd14:   r = a | b;
      8'd15:   r = b;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  // Replace the bits selected by m.
  function automatic logic [15:0] merge16(input logic [15:0] old, input logic [15:0] val,
                                          input logic [15:0] m);
    return (old & ~m) | (val & m);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rfa_ctrl.sv -----
// Controller state machine of the raster frame-buffer device.
`default_nettype none

module rfa_ctrl
  import rfa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The result register can take a new item when it is empty or being drained.
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    in_stall   = !((state_r == S_IDLE) || ((state_r == S_WRITE) && slot_free));
    cmd.clear  = (state_r == S_CLEAR);
    cmd.load   = in_valid && !in_stall;
    cmd.rd     = (state_r == S_READ);
    cmd.commit = (state_r == S_WRITE) && slot_free;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.load) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (slot_free) state_nxt = cmd.load ? S_READ : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid flag.
  always_comb begin
    priority if (cmd.commit) out_valid_nxt = 1'b1;
    else if (!out_stall)     out_valid_nxt = 1'b0;
    else                     out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- hdl/rfa_datapath.sv -----
// Datapath of the raster frame-buffer device: decode, memories, registers and ALU.
`default_nettype none

module rfa_datapath
  import rfa_pkg::*;
#(
  parameter int NUM_BUFFERS  = 16,
  parameter int BUFFER_WORDS = 16384
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [17:0] in_bus_address,
  input  wire logic [15:0] in_write_data,
  input  wire logic        in_from_host_side,
  output logic [15:0]      out_read_data,
  output logic             out_claimed
);

  localparam int DEPTH = NUM_BUFFERS * BUFFER_WORDS;
  localparam int FA_W  = $clog2(DEPTH);
  localparam int SEL_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

  // Storage.
  logic [15:0] fm_mem [DEPTH];
  logic [15:0] csa_mem [NUM_BUFFERS];
  logic [15:0] fm_rdata_r;
  logic [15:0] csa_rdata_r;

  // Architectural registers.
  logic [15:0] ctrl0_r, ctrl0_nxt;
  logic [15:0] ctrl1_r, ctrl1_nxt;
  logic [15:0] kstat_r, kstat_nxt;
  logic [17:0] khigh_r, khigh_nxt;
  logic [6:0]  klow_r, klow_nxt;

  // Clearing pass counter.
  logic [FA_W-1:0] clr_cnt_r;

  // Decoded item.
  logic [1:0]       kind_r;
  logic             side_r;
  logic [15:0]      data_r;
  logic             hi_lane_r;
  logic [7:0]       op_r;
  logic [SEL_W-1:0] csel_r;
  logic [FA_W-1:0]  fa_r;
  logic             fr_acc_r;
  logic             csa_acc_r;
  reg_sel_t         rsel_r;
  logic             claim_r;

  // Result registers.
  logic [15:0] rd_data_r, rd_data_nxt;
  logic        claim_out_r;

  // Decode signals.
  logic [15:0]      cur_ctrl;
  logic [7:0]       sel;
  logic             sel_ok;
  logic             in_window;
  logic             at_csa;
  logic [16:0]      word_off;
  logic             w_ok;
  logic [17:0]      even_addr;
  logic [17:0]      reg_addr;
  reg_sel_t         rsel;
  logic [FA_W-1:0]  fa;

  // Write-back signals.
  logic [15:0] item_ctrl;
  logic [15:0] lane_mask;
  logic [15:0] old_val;
  logic [15:0] alu_val;
  logic [15:0] wb_val;
  logic        fm_we;
  logic [FA_W-1:0] fm_waddr;
  logic [15:0] fm_wdata;

  // Decode of the incoming item against the current control register.
  always_comb begin
    cur_ctrl  = in_from_host_side ? ctrl1_r : ctrl0_r;
    sel       = cur_ctrl[7:0];
    sel_ok    = (32'(sel) < NUM_BUFFERS);
    in_window = (in_bus_address >= WIN_LO) && (in_bus_address < WIN_HI);
    even_addr = {in_bus_address[17:1], 1'b0};
    at_csa    = (in_req_type == REQ_WORD) ? (in_bus_address == CSA_ADDR)
                                          : (even_addr == CSA_ADDR);
    word_off  = in_bus_address[17:1] - WIN_WORD_BASE;
    w_ok      = (32'(word_off) < BUFFER_WORDS);
    fa        = FA_W'(sel[SEL_W-1:0]) * FA_W'(BUFFER_WORDS) + FA_W'(word_off);
    reg_addr  = (in_req_type == REQ_BYTE) ? even_addr : in_bus_address;
    priority if (reg_addr == CTRL_ADDR)  rsel = REG_CTRL;
    else if (reg_addr == KSTAT_ADDR)     rsel = REG_KSTAT;
    else if (reg_addr == KADDR_ADDR)     rsel = REG_KADDR;
    else if ((reg_addr == CTRL_SPARE_ADDR) || (reg_addr == VSW_ADDR) ||
             (reg_addr == ASW_ADDR))     rsel = REG_DUMMY;
    else                                 rsel = REG_NONE;
    if (in_window || (in_req_type == REQ_UNUSED)) rsel = REG_NONE;
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_req_type;
      side_r    <= in_from_host_side;
      data_r    <= in_write_data;
      hi_lane_r <= in_bus_address[0];
      op_r      <= cur_ctrl[15:8];
      csel_r    <= sel[SEL_W-1:0];
      fa_r      <= fa;
      fr_acc_r  <= (in_req_type != REQ_UNUSED) && in_window && sel_ok && !at_csa && w_ok;
      csa_acc_r <= (in_req_type != REQ_UNUSED) && in_window && sel_ok && at_csa;
      rsel_r    <= rsel;
      claim_r   <= (in_req_type != REQ_UNUSED) && (in_window || (rsel != REG_NONE));
    end
  end

  // Control and keyboard register updates, done in the read cycle.
  always_comb begin
    ctrl0_nxt = ctrl0_r;
    ctrl1_nxt = ctrl1_r;
    kstat_nxt = kstat_r;
    khigh_nxt = khigh_r;
    klow_nxt  = klow_r;
    if (cmd.rd) begin
      if (rsel_r == REG_CTRL && kind_r == REQ_WORD) begin
        if (side_r) ctrl1_nxt = data_r;
        else        ctrl0_nxt = data_r;
      end else if (rsel_r == REG_CTRL && kind_r == REQ_BYTE) begin
        if (side_r) ctrl1_nxt = merge16(ctrl1_r, data_r, lane_mask);
        else        ctrl0_nxt = merge16(ctrl0_r, data_r, lane_mask);
      end else if (rsel_r == REG_KSTAT && kind_r == REQ_WORD) begin
        kstat_nxt = data_r & KSTAT_MASK;
        khigh_nxt = {data_r[1:0], khigh_r[15:0]};
      end else if (rsel_r == REG_KADDR && kind_r == REQ_WORD) begin
        klow_nxt  = data_r[6:0] & KADDR_LO_MASK;
        khigh_nxt = {2'b00, data_r & KADDR_HI_MASK};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl0_r <= '0;
      ctrl1_r <= '0;
      kstat_r <= '0;
      khigh_r <= '0;
      klow_r  <= '0;
    end else begin
      ctrl0_r <= ctrl0_nxt;
      ctrl1_r <= ctrl1_nxt;
      kstat_r <= kstat_nxt;
      khigh_r <= khigh_nxt;
      klow_r  <= klow_nxt;
    end
  end

  // Clearing pass counter, one word per cycle after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign sts.clear_last = (clr_cnt_r == FA_W'(DEPTH - 1));

  // ALU and byte-lane merge for the write-back.
  always_comb begin
    item_ctrl = side_r ? ctrl1_r : ctrl0_r;
    lane_mask = hi_lane_r ? 16'hFF00 : 16'h00FF;
    old_val   = fr_acc_r ? fm_rdata_r : csa_rdata_r;
    alu_val   = alu_apply(op_r, old_val, data_r);
    wb_val    = (kind_r == REQ_BYTE) ? merge16(old_val, alu_val, lane_mask) : alu_val;
    fm_we     = cmd.clear || (cmd.commit && fr_acc_r && (kind_r != REQ_READ));
    fm_waddr  = cmd.clear ? clr_cnt_r : fa_r;
    fm_wdata  = cmd.clear ? 16'h0000 : wb_val;
  end

  // Frame memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (fm_we) begin
      fm_mem[fm_waddr] <= fm_wdata;
    end
    if (cmd.rd && fr_acc_r) begin
      fm_rdata_r <= fm_mem[fa_r];
    end
  end

  // CSA word store.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      if (32'(clr_cnt_r) < NUM_BUFFERS) begin
        csa_mem[clr_cnt_r[SEL_W-1:0]] <= 16'h0000;
      end
    end else if (cmd.commit && csa_acc_r && (kind_r != REQ_READ)) begin
      csa_mem[csel_r] <= wb_val;
    end
    if (cmd.rd && csa_acc_r) begin
      csa_rdata_r <= csa_mem[csel_r];
    end
  end

  // Read data selection.
  always_comb begin
    rd_data_nxt = 16'h0000;
    if (kind_r == REQ_READ) begin
      priority if (fr_acc_r)       rd_data_nxt = fm_rdata_r;
      else if (csa_acc_r)          rd_data_nxt = csa_rdata_r;
      else if (rsel_r == REG_CTRL) rd_data_nxt = item_ctrl;
      else if (rsel_r == REG_KSTAT)
        rd_data_nxt = {kstat_r[15:5], 5'b00000} | {14'b0, khigh_r[17:16]};
      else if (rsel_r == REG_KADDR)
        rd_data_nxt = khigh_r[15:0] | {9'b0, klow_r};
      else                         rd_data_nxt = 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rd_data_r   <= rd_data_nxt;
      claim_out_r <= claim_r;
    end
  end

  assign out_read_data = rd_data_r;
  assign out_claimed   = claim_out_r;

endmodule

`default_nettype wire

// ----- hdl/raster_framebuffer_alu_device.sv -----
// Top level of the raster frame-buffer device with a boolean ALU on the write path.
`default_nettype none

// Bus-attached bitmap display device. Each item is one bus access (read, word write or
// byte write); each produces exactly one result carrying the read data and whether the
// address belongs to the device. After reset the device runs a clearing pass over the
// frame memory, one word per cycle over all NUM_BUFFERS * BUFFER_WORDS words (262144 with
// the default sizes), and holds in_stall high until it ends. After that each accepted item
// passes through a read state, in which the frame memory reads the old word, and a
// write-back state, in which the ALU result is written back and the result is registered;
// the next item can be taken in the write-back state when the result register is free.
// A finished result waits in an output register, so the device keeps accepting while
// out_stall is high until one more result is ready.
module raster_framebuffer_alu_device
  import rfa_pkg::*;
#(
  parameter int NUM_BUFFERS  = 16,
  parameter int BUFFER_WORDS = 16384
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [17:0] in_bus_address,
  input  wire logic [15:0] in_write_data,
  input  wire logic        in_from_host_side,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_read_data,
  output logic             out_claimed
);

  cmd_t cmd;
  sts_t sts;

  // Sequencing of each item.
  rfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Decode, storage and ALU.
  rfa_datapath #(
    .NUM_BUFFERS  (NUM_BUFFERS),
    .BUFFER_WORDS (BUFFER_WORDS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_req_type),
    .in_bus_address    (in_bus_address),
    .in_write_data     (in_write_data),
    .in_from_host_side (in_from_host_side),
    .out_read_data     (out_read_data),
    .out_claimed       (out_claimed)
  );

endmodule

`default_nettype wire

// ----- tb/sv/rfa_access_checker.sv -----
// Checker for the raster frame-buffer device: shadows its state and compares every result.
`timescale 1ns / 1ps

module rfa_access_checker
  import rfa_pkg::*;
#(
  parameter int NUM_BUFFERS  = 16,
  parameter int BUFFER_WORDS = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [17:0] in_bus_address,
  input  logic [15:0] in_write_data,
  input  logic        in_from_host_side,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_read_data,
  input  logic        out_claimed,
  output int          error_count,
  output int          awaited_count,
  output int          checked_count
);

  // Boolean functions of the write-path ALU, selected by the control high byte.
  typedef enum logic [7:0] {
    ALU_NOT_B = 8'd0, ALU_NOR, ALU_A_AND_NOT_B, ALU_ZERO, ALU_INV_AND, ALU_NOT_A, ALU_XOR,
    ALU_NOT_A_AND_B, ALU_A_OR_NOT_B, ALU_XNOR, ALU_KEEP_A, ALU_AND, ALU_NOT_A_OR_B,
    ALU_ONES, ALU_OR, ALU_PASS_B
  } alu_func_t;

  // One result item as the device should return it.
  typedef struct packed {
    logic [15:0] read_data;
    logic        claimed;
  } bus_result_t;

  localparam int          FRAME_WORDS = NUM_BUFFERS * BUFFER_WORDS;
  localparam logic [15:0] LOW_LANE    = 16'h00FF;
  localparam logic [15:0] HIGH_LANE   = 16'hFF00;
  localparam int          PRINT_LIMIT = 60;

  // Shadow copy of the device state.
  logic [15:0] frame_words [FRAME_WORDS];
  logic [15:0] csa_words [NUM_BUFFERS];
  logic [15:0] ctrl_host0;
  logic [15:0] ctrl_host1;
  logic [15:0] kbd_status;
  logic [17:0] kbd_addr_hi;
  logic [6:0]  kbd_addr_lo;

  bus_result_t awaited_results[$];
  bus_result_t oldest_result;
  bus_result_t new_result;
  int          errors;
  int          checked;
  bit          state_cleared;

  function automatic logic [15:0] alu_result(input logic [7:0] func, input logic [15:0] a,
                                             input logic [15:0] b);
    case (func)
      ALU_NOT_B:       return ~b;
      ALU_NOR:         return ~(a | b);
      ALU_A_AND_NOT_B: return a & ~b;
      ALU_ZERO:        return 16'h0000;
      ALU_INV_AND:     return ~(a & b);
      ALU_NOT_A:       return ~a;
      ALU_XOR:         return a ^ b;
      ALU_NOT_A_AND_B: return ~a & b;
      ALU_A_OR_NOT_B:  return a | ~b;
      ALU_XNOR:        return ~(a ^ b);
      ALU_KEEP_A:      return a;
      ALU_AND:         return a & b;
      ALU_NOT_A_OR_B:  return ~a | b;
      ALU_ONES:        return 16'hFFFF;
      ALU_OR:          return a | b;
      ALU_PASS_B:      return b;
      default:         return 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] lane_merge(input logic [15:0] old, input logic [15:0] val,
                                             input logic [15:0] lane);
    return (old & ~lane) | (val & lane);
  endfunction

  task automatic clear_state();
    foreach (frame_words[i]) frame_words[i] = 16'h0000;
    foreach (csa_words[i]) csa_words[i] = 16'h0000;
    ctrl_host0  = 16'h0000;
    ctrl_host1  = 16'h0000;
    kbd_status  = 16'h0000;
    kbd_addr_hi = 18'h00000;
    kbd_addr_lo = 7'h00;
  endtask

  // Applies one bus access to the shadow state and returns what the device should answer.
  task automatic device_response(input logic [1:0] kind, input logic [17:0] addr,
                                 input logic [15:0] data, input logic side,
                                 output bus_result_t res);
    logic [15:0] ctrl;
    logic [15:0] lane;
    logic [17:0] even_addr;
    logic [7:0]  sel;
    logic [7:0]  func;
    logic        at_csa;
    logic        dummy_word;
    int unsigned word;
    int unsigned idx;
    logic [15:0] old_word;
    ctrl       = side ? ctrl_host1 : ctrl_host0;
    sel        = ctrl[7:0];
    func       = ctrl[15:8];
    lane       = addr[0] ? HIGH_LANE : LOW_LANE;
    even_addr  = {addr[17:1], 1'b0};
    dummy_word = (addr == CTRL_SPARE_ADDR) || (addr == VSW_ADDR) || (addr == ASW_ADDR);
    res        = '0;
    if (kind != REQ_READ && kind != REQ_WORD && kind != REQ_BYTE) begin
      // The unused request code is ignored outright.
      res = '0;
    end else if (addr >= WIN_LO && addr < WIN_HI) begin
      // Frame-buffer window: claimed even when the selected buffer does not exist.
      res.claimed = 1'b1;
      if (int'(sel) < NUM_BUFFERS) begin
        at_csa = (kind == REQ_WORD) ? (addr == CSA_ADDR) : (even_addr == CSA_ADDR);
        word   = 32'(addr[17:1]) - 32'(WIN_LO[17:1]);
        if (at_csa) begin
          case (kind)
            REQ_READ: res.read_data = csa_words[sel];
            REQ_WORD: csa_words[sel] = alu_result(func, csa_words[sel], data);
            default:  csa_words[sel] = lane_merge(csa_words[sel],
                                                  alu_result(func, csa_words[sel], data), lane);
          endcase
        end else if (word < BUFFER_WORDS) begin
          idx      = int'(sel) * BUFFER_WORDS + word;
          old_word = frame_words[idx];
          case (kind)
            REQ_READ: res.read_data = old_word;
            REQ_WORD: frame_words[idx] = alu_result(func, old_word, data);
            default:  frame_words[idx] = lane_merge(old_word, alu_result(func, old_word, data),
                                                    lane);
          endcase
        end
      end
    end else if (kind == REQ_BYTE) begin
      // Byte writes reach only the control register; other registers swallow them.
      if (even_addr == CTRL_ADDR) begin
        res.claimed = 1'b1;
        if (side) ctrl_host1 = lane_merge(ctrl_host1, data, lane);
        else ctrl_host0 = lane_merge(ctrl_host0, data, lane);
      end else if (even_addr == CTRL_SPARE_ADDR || even_addr == KSTAT_ADDR ||
                   even_addr == KADDR_ADDR || even_addr == VSW_ADDR || even_addr == ASW_ADDR) begin
        res.claimed = 1'b1;
      end
    end else if (kind == REQ_WORD) begin
      res.claimed = 1'b1;
      if (addr == CTRL_ADDR) begin
        if (side) ctrl_host1 = data;
        else ctrl_host0 = data;
      end else if (addr == KSTAT_ADDR) begin
        // The two low data bits land in the top of the keyboard address.
        kbd_status  = data & KSTAT_MASK;
        kbd_addr_hi = {data[1:0], kbd_addr_hi[15:0]};
      end else if (addr == KADDR_ADDR) begin
        kbd_addr_lo = data[6:0] & KADDR_LO_MASK;
        kbd_addr_hi = {2'b00, data & KADDR_HI_MASK};
      end else if (!dummy_word) begin
        res.claimed = 1'b0;
      end
    end else begin
      res.claimed = 1'b1;
      if (addr == CTRL_ADDR) begin
        res.read_data = ctrl;
      end else if (addr == KSTAT_ADDR) begin
        res.read_data = (kbd_status & KSTAT_MASK) | {14'd0, kbd_addr_hi[17:16]};
      end else if (addr == KADDR_ADDR) begin
        res.read_data = kbd_addr_hi[15:0] | {9'd0, kbd_addr_lo};
      end else if (!dummy_word) begin
        res.claimed = 1'b0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (errors < PRINT_LIMIT) begin
      $display("%0t mismatch in %s: got %h, expected %h", $time, what, got, want);
    end
    errors++;
  endtask

  // Results are checked before new items are predicted, so an item taken at this edge
  // can never be matched against a result leaving at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      if (!state_cleared) clear_state();
      state_cleared = 1'b1;
      awaited_results.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no access outstanding", out_read_data, 16'h0000);
        end else begin
          oldest_result = awaited_results.pop_front();
          checked++;
          if (out_read_data !== oldest_result.read_data) begin
            report_mismatch("read data", out_read_data, oldest_result.read_data);
          end
          if (out_claimed !== oldest_result.claimed) begin
            report_mismatch("claimed flag", {15'd0, out_claimed},
                            {15'd0, oldest_result.claimed});
          end
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        device_response(in_req_type, in_bus_address, in_write_data, in_from_host_side,
                        new_result);
        awaited_results.push_back(new_result);
      end
    end
    error_count   <= errors;
    awaited_count <= awaited_results.size();
    checked_count <= checked;
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the raster frame-buffer device testbench: clock, reset, bus stimulus and verdict.
`timescale 1ns / 1ps

module testbench
  import rfa_pkg::*;
();

  localparam int NUM_BUFFERS    = 16;
  localparam int BUFFER_WORDS   = 16384;
  localparam int CLEAR_CYCLES   = NUM_BUFFERS * BUFFER_WORDS;
  localparam int WATCHDOG_LIMIT = 3 * CLEAR_CYCLES;
  localparam int RANDOM_ITEMS   = 1125;
  localparam int SETTLE_CYCLES  = 20;
  localparam int ALU_FUNCS      = 16;

  // Control register fields used by the directed accesses.
  localparam logic [7:0] FUNC_XOR         = 8'd6;
  localparam logic [7:0] FUNC_PASS_B      = 8'd15;
  localparam logic [7:0] FUNC_UNKNOWN     = 8'd16;
  localparam logic [7:0] BUF_FIRST        = 8'd0;
  localparam logic [7:0] BUF_OUT_OF_RANGE = 8'hFF;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [17:0] in_bus_address;
  logic [15:0] in_write_data;
  logic        in_from_host_side;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_read_data;
  logic        out_claimed;

  int error_count;
  int awaited_count;
  int checked_count;
  int quiet_cycles;
  int reads_sent;
  int word_writes_sent;
  int byte_writes_sent;
  int unused_sent;
  bit idle_on;

  raster_framebuffer_alu_device #(
    .NUM_BUFFERS (NUM_BUFFERS),
    .BUFFER_WORDS(BUFFER_WORDS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_bus_address   (in_bus_address),
    .in_write_data    (in_write_data),
    .in_from_host_side(in_from_host_side),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_claimed      (out_claimed)
  );

  rfa_access_checker #(
    .NUM_BUFFERS (NUM_BUFFERS),
    .BUFFER_WORDS(BUFFER_WORDS)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_bus_address   (in_bus_address),
    .in_write_data    (in_write_data),
    .in_from_host_side(in_from_host_side),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_claimed      (out_claimed),
    .error_count      (error_count),
    .awaited_count    (awaited_count),
    .checked_count    (checked_count)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls come in random bursts while idling is enabled.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Ends the run when neither channel moves for far longer than the clearing pass.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without an accepted item.", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one bus access, with an optional gap before it, and waits until it is taken.
  task automatic send_access(input logic [1:0] kind, input logic [17:0] addr,
                             input logic [15:0] data, input logic side);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= kind;
    in_bus_address    <= addr;
    in_write_data     <= data;
    in_from_host_side <= side;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    case (kind)
      REQ_READ: reads_sent++;
      REQ_WORD: word_writes_sent++;
      REQ_BYTE: byte_writes_sent++;
      default:  unused_sent++;
    endcase
  endtask

  // Holds the sender off until every outstanding access has returned its result.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
  endtask

  // Mostly small buffer numbers and known functions, sometimes neither.
  function automatic logic [15:0] random_control();
    logic [7:0] sel;
    logic [7:0] func;
    sel  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(NUM_BUFFERS, 255))
                                       : 8'($urandom_range(0, 3));
    func = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(ALU_FUNCS, 255))
                                       : 8'($urandom_range(0, ALU_FUNCS - 1));
    return {func, sel};
  endfunction

  task automatic pick_random_access(output logic [1:0] kind, output logic [17:0] addr,
                                    output logic [15:0] data, output logic side);
    int unsigned roll;
    int unsigned word;
    roll = $urandom_range(0, 9);
    kind = (roll < 4) ? REQ_READ : ((roll < 7) ? REQ_WORD : REQ_BYTE);
    data = 16'($urandom_range(0, 16'hFFFF));
    side = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // New buffer and function for one host.
      kind = REQ_WORD;
      addr = CTRL_ADDR;
      data = random_control();
    end else if (roll < 11) begin
      kind = REQ_BYTE;
      addr = CTRL_ADDR | 18'($urandom_range(0, 1));
      data = random_control();
    end else if (roll < 18) begin
      // Register block, sometimes at an odd address.
      case ($urandom_range(0, 5))
        0:       addr = CTRL_ADDR;
        1:       addr = CTRL_SPARE_ADDR;
        2:       addr = KSTAT_ADDR;
        3:       addr = KADDR_ADDR;
        4:       addr = VSW_ADDR;
        default: addr = ASW_ADDR;
      endcase
      addr[0] = ($urandom_range(0, 3) == 0);
    end else if (roll < 22) begin
      // Noise over the whole address space, the unused request code included.
      kind = 2'($urandom_range(0, 3));
      addr = 18'($urandom_range(0, 18'h3FFFF));
    end else begin
      // Window access, mostly to a few hot words so reads see earlier writes;
      // the top word doubles as the CSA word.
      roll = $urandom_range(0, 9);
      if (roll < 6) word = $urandom_range(0, 7);
      else if (roll < 8) word = $urandom_range(BUFFER_WORDS - 4, BUFFER_WORDS - 1);
      else word = $urandom_range(0, BUFFER_WORDS - 1);
      addr    = WIN_LO + 18'(word << 1);
      addr[0] = 1'($urandom_range(0, 1));
    end
  endtask

  // Reset, directed accesses, random phases, then the verdict.
  initial begin
    logic [1:0]  kind;
    logic [17:0] addr;
    logic [15:0] data;
    logic        side;
    reads_sent        = 0;
    word_writes_sent  = 0;
    byte_writes_sent  = 0;
    unused_sent       = 0;
    idle_on           = 1'b0;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_req_type       <= REQ_READ;
    in_bus_address    <= 18'h00000;
    in_write_data     <= 16'h0000;
    in_from_host_side <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Window writes and reads, the CSA word and the odd word beside it.
    send_access(REQ_READ, CTRL_ADDR, 16'h0000, 1'b0);
    send_access(REQ_WORD, CTRL_ADDR, {FUNC_PASS_B, BUF_FIRST}, 1'b0);
    send_access(REQ_WORD, WIN_LO, 16'hFFFF, 1'b0);
    send_access(REQ_READ, WIN_LO, 16'h0000, 1'b0);
    send_access(REQ_WORD, CSA_ADDR + 18'd1, 16'h1234, 1'b0);
    send_access(REQ_WORD, CSA_ADDR, 16'h5678, 1'b0);
    send_access(REQ_BYTE, CSA_ADDR + 18'd1, 16'hAB00, 1'b0);
    send_access(REQ_READ, CSA_ADDR + 18'd1, 16'h0000, 1'b0);
    send_access(REQ_WORD, CTRL_ADDR, {FUNC_XOR, BUF_FIRST}, 1'b0);
    send_access(REQ_BYTE, WIN_LO + 18'd1, 16'h0FF0, 1'b0);
    send_access(REQ_READ, WIN_LO, 16'h0000, 1'b0);
    // Second host: unknown function, then a buffer number out of range.
    send_access(REQ_BYTE, CTRL_ADDR + 18'd1, {FUNC_UNKNOWN, 8'h00}, 1'b1);
    send_access(REQ_WORD, WIN_LO, 16'hFFFF, 1'b1);
    send_access(REQ_BYTE, CTRL_ADDR, {8'h00, BUF_OUT_OF_RANGE}, 1'b1);
    send_access(REQ_WORD, WIN_LO, 16'h0000, 1'b1);
    send_access(REQ_READ, WIN_LO, 16'h0000, 1'b1);
    send_access(REQ_READ, WIN_LO, 16'h0000, 1'b0);
    // Keyboard registers and the claimed-but-inert addresses.
    send_access(REQ_WORD, KSTAT_ADDR, 16'hFFFF, 1'b0);
    send_access(REQ_READ, KSTAT_ADDR, 16'h0000, 1'b0);
    send_access(REQ_WORD, KADDR_ADDR, 16'hFFFF, 1'b0);
    send_access(REQ_READ, KADDR_ADDR, 16'h0000, 1'b0);
    send_access(REQ_READ, KSTAT_ADDR, 16'h0000, 1'b1);
    send_access(REQ_BYTE, KSTAT_ADDR + 18'd1, 16'hFFFF, 1'b0);
    send_access(REQ_READ, CTRL_ADDR + 18'd1, 16'h0000, 1'b0);
    send_access(REQ_READ, CTRL_SPARE_ADDR, 16'h0000, 1'b0);
    send_access(REQ_WORD, VSW_ADDR, 16'hFFFF, 1'b0);
    send_access(REQ_READ, ASW_ADDR, 16'h0000, 1'b1);
    send_access(REQ_UNUSED, WIN_LO, 16'hFFFF, 1'b0);
    send_access(REQ_READ, 18'h3FFFF, 16'h0000, 1'b1);
    send_access(REQ_WORD, 18'h00000, 16'h0000, 1'b0);
    drain_results();

    // Random phases: idling, none, idling again, and a clean tail.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 400 || i == 650 || i == 975) drain_results();
      idle_on = (i < 400) || (i >= 650 && i < 975);
      pick_random_access(kind, addr, data, side);
      send_access(kind, addr, data, side);
    end
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d accesses: %0d reads, %0d word writes, %0d byte writes, %0d unused.",
             reads_sent + word_writes_sent + byte_writes_sent + unused_sent, reads_sent,
             word_writes_sent, byte_writes_sent, unused_sent);
    $display("Compared %0d results covering the window, CSA words and register block.",
             checked_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
